// ----- hw/rtl/sigf_pkg.sv -----
// Shared constants, codes and types of the serial idle gap framer.
// No dependencies; every other file of the block but sigf_if uses this package.
package sigf_pkg;

	localparam int MAX_FRAME = 64;
	localparam int ADDR_W    = $clog2(MAX_FRAME);
	localparam int CNT_W     = $clog2(MAX_FRAME + 1);
	localparam int PADDR_W   = 3;

	localparam logic [7:0]  COLON_BYTE = 8'h3A;
	localparam logic [15:0] GAP_RESET  = 16'd100;
	localparam logic [15:0] SIL_MAX    = 16'hFFFF;

	localparam logic [1:0] CAUSE_GAP   = 2'd0;
	localparam logic [1:0] CAUSE_START = 2'd1;
	localparam logic [1:0] CAUSE_FULL  = 2'd2;

	localparam logic ACT_BYTE = 1'b0;
	localparam logic ACT_TICK = 1'b1;

	localparam logic REG_ASCII = 1'b0;
	localparam logic REG_GAP   = 1'b1;

	typedef logic [7:0] byte_t;

	typedef struct packed {
		logic        ascii_mode;
		logic [15:0] gap_ticks;
	} cfg_t;

endpackage

// ----- hw/rtl/sigf_if.sv -----
// Request channels of the framer: received bus events in, frame bytes out.
// Depends on nothing; payload widths are fixed by the field definitions.
interface sigf_rx_if;
	logic       valid;
	logic       ready;
	logic       action;
	logic [7:0] rx_byte;

	modport source (output valid, output action, output rx_byte, input ready);
	modport sink (input valid, input action, input rx_byte, output ready);
endinterface

interface sigf_frame_if;
	logic       valid;
	logic       ready;
	logic [7:0] frame_byte;
	logic       frame_last;
	logic [1:0] end_cause;

	modport source (output valid, output frame_byte, output frame_last, output end_cause,
		input ready);
	modport sink (input valid, input frame_byte, input frame_last, input end_cause,
		output ready);
endinterface

// ----- hw/rtl/serial_idle_gap_framer.sv -----
// Channel  Dir  Payload                              Accepted when
// rx       in   action, rx_byte                      rx.valid && rx.ready
// frame    out  frame_byte, frame_last, end_cause    frame.valid && frame.ready
// apb      in   paddr, pwdata (ascii_mode, gap_ticks) psel && penable && pwrite
//
// A byte or tick that ends no frame is taken in the idle state, which the block keeps.
// A frame of n bytes is read out of the store byte by byte, each by a memory read (S_RD)
// then an output load (S_WAIT), so the block is busy for the readout plus output stalls.
// rx.ready is low during readout; the output register lets the next request in
// while the last frame byte still waits. No clearing pass after reset.
// Top level of the framer; depends on sigf_pkg, sigf_if, sigf_store, sigf_cfg.
module serial_idle_gap_framer (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [sigf_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	sigf_rx_if.sink                     rx,
	sigf_frame_if.source                frame
);
	import sigf_pkg::*;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_RD   = 2'd1;
	localparam logic [1:0] S_WAIT = 2'd2;

	cfg_t cfg;

	logic [1:0]       st_q;
	logic [CNT_W-1:0] fill_q;
	logic [15:0]      silence_q;
	logic [CNT_W-1:0] len_q;
	logic [ADDR_W-1:0] idx_q;
	logic [1:0]       cause_q;
	logic             pend_colon_q;

	logic       frame_v_q;
	byte_t      frame_byte_q;
	logic       frame_last_q;
	logic [1:0] frame_cause_q;

	logic             accept;
	logic             is_colon;
	logic [15:0]      sil_inc;
	logic [CNT_W-1:0] fill_inc;
	logic             load;
	logic             last;
	logic             done;

	logic              we;
	logic [ADDR_W-1:0] waddr;
	byte_t             wdata;
	byte_t             rdata;

	sigf_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	sigf_store u_store (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (st_q == S_RD),
		.raddr (idx_q),
		.rdata (rdata)
	);

	assign rx.ready = (st_q == S_IDLE);
	assign accept   = rx.valid && rx.ready;
	assign is_colon = cfg.ascii_mode && (rx.rx_byte == COLON_BYTE);
	assign sil_inc  = (silence_q == SIL_MAX) ? silence_q : silence_q + 16'd1;
	assign fill_inc = fill_q + CNT_W'(1);

	assign load = (st_q == S_WAIT) && (!frame_v_q || frame.ready);
	assign last = (CNT_W'(idx_q) + CNT_W'(1)) == len_q;
	assign done = load && last;

	always_comb begin
		we    = 1'b0;
		waddr = fill_q[ADDR_W-1:0];
		wdata = rx.rx_byte;
		if (done && pend_colon_q) begin
			we    = 1'b1;
			waddr = '0;
			wdata = COLON_BYTE;
		end else if (accept && rx.action == ACT_BYTE) begin
			if (is_colon) begin
				we    = (fill_q == '0);
				waddr = '0;
			end else begin
				we = (fill_q < CNT_W'(MAX_FRAME));
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q         <= S_IDLE;
			fill_q       <= '0;
			silence_q    <= '0;
			len_q        <= '0;
			idx_q        <= '0;
			cause_q      <= CAUSE_GAP;
			pend_colon_q <= 1'b0;
		end else begin
			unique case (st_q)
				S_IDLE: begin
					if (accept) begin
						idx_q        <= '0;
						pend_colon_q <= 1'b0;
						if (rx.action == ACT_TICK) begin
							silence_q <= sil_inc;
							if (sil_inc > cfg.gap_ticks && fill_q != '0) begin
								len_q   <= fill_q;
								cause_q <= CAUSE_GAP;
								fill_q  <= '0;
								st_q    <= S_RD;
							end
						end else begin
							silence_q <= '0;
							if (is_colon) begin
								fill_q <= CNT_W'(1);
								if (fill_q != '0) begin
									len_q        <= fill_q;
									cause_q      <= CAUSE_START;
									pend_colon_q <= 1'b1;
									st_q         <= S_RD;
								end
							end else if (fill_q < CNT_W'(MAX_FRAME)) begin
								if (fill_inc == CNT_W'(MAX_FRAME)) begin
									len_q   <= fill_inc;
									cause_q <= CAUSE_FULL;
									fill_q  <= '0;
									st_q    <= S_RD;
								end else begin
									fill_q <= fill_inc;
								end
							end
						end
					end
				end
				S_RD: begin
					st_q <= S_WAIT;
				end
				S_WAIT: begin
					if (load) begin
						idx_q <= idx_q + ADDR_W'(1);
						st_q  <= last ? S_IDLE : S_RD;
					end
				end
				default: begin
					st_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_v_q <= 1'b0;
		end else if (load) begin
			frame_v_q <= 1'b1;
		end else if (frame.ready) begin
			frame_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			frame_byte_q  <= rdata;
			frame_last_q  <= last;
			frame_cause_q <= cause_q;
		end
	end

	assign frame.valid      = frame_v_q;
	assign frame.frame_byte = frame_byte_q;
	assign frame.frame_last = frame_last_q;
	assign frame.end_cause  = frame_cause_q;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q < CNT_W'(MAX_FRAME))
		else $error("fill count reached the store depth");

	a_full_emits: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && rx.action == ACT_BYTE && !is_colon && fill_inc == CNT_W'(MAX_FRAME))
		|=> (st_q == S_RD && fill_q == '0 && cause_q == CAUSE_FULL))
		else $error("full store did not start a readout");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> (st_q == S_IDLE && frame.valid && frame.frame_last))
		else $error("last frame byte did not end the readout");

	a_no_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == S_RD) |-> (len_q != '0))
		else $error("readout of an empty frame");

	a_colon_restore: assert property (@(posedge clk) disable iff (!arst_n)
		(done && pend_colon_q) |-> (we && waddr == '0 && fill_q == CNT_W'(1)))
		else $error("start byte not stored after readout");

endmodule

// ----- hw/rtl/sigf_store.sv -----
// Frame store: one write port, one read port, registered read data.
// Depends on sigf_pkg for depth and address width.
module sigf_store (
	input  logic                       clk,
	input  logic                       we,
	input  logic [sigf_pkg::ADDR_W-1:0] waddr,
	input  sigf_pkg::byte_t            wdata,
	input  logic                       re,
	input  logic [sigf_pkg::ADDR_W-1:0] raddr,
	output sigf_pkg::byte_t            rdata
);
	import sigf_pkg::*;

	byte_t mem [MAX_FRAME];
	byte_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- hw/rtl/sigf_cfg.sv -----
// APB register file of the framer: ascii_mode at 0x0, gap_ticks at 0x4.
// Depends on sigf_pkg for register indexes and the configuration struct.
module sigf_cfg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [sigf_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	output sigf_pkg::cfg_t              cfg
);
	import sigf_pkg::*;

	logic        ascii_mode_q;
	logic [15:0] gap_ticks_q;
	logic        wr;
	logic        sel;

	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite;
	assign sel    = paddr[2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ascii_mode_q <= 1'b0;
			gap_ticks_q  <= GAP_RESET;
		end else if (wr) begin
			unique case (sel)
				REG_ASCII: ascii_mode_q <= pwdata[0];
				REG_GAP:   gap_ticks_q  <= pwdata[15:0];
				default:   ;
			endcase
		end
	end

	always_comb begin
		unique case (sel)
			REG_ASCII: prdata = {31'd0, ascii_mode_q};
			REG_GAP:   prdata = {16'd0, gap_ticks_q};
			default:   prdata = 32'd0;
		endcase
	end

	assign cfg = '{ascii_mode: ascii_mode_q, gap_ticks: gap_ticks_q};

endmodule

// ----- bench/sigf_frame_checker.sv -----
`timescale 1ns / 100ps
// Frame checker for the serial idle gap framer: follows register writes and accepted
// bus events, predicts every frame byte and compares it with the frame channel.
// Depends on sigf_pkg and the sigf_rx_if / sigf_frame_if interfaces.
module sigf_frame_checker (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [sigf_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                  pwdata,
	input  logic                         pready,
	sigf_rx_if                           rx,
	sigf_frame_if                        frame,
	output int                           fails,
	output int                           pending
);
	import sigf_pkg::*;

	typedef struct packed {
		byte_t      data;
		logic       last;
		logic [1:0] cause;
	} frame_beat_t;

	frame_beat_t             frame_due [$];
	byte_t                   held_bytes [MAX_FRAME];
	logic [CNT_W-1:0]        held;
	logic [15:0]             quiet;
	cfg_t                    cfg;

	task automatic queue_frame(input logic [1:0] cause);
		for (int k = 0; k < held; k++) begin
			frame_due.push_back(frame_beat_t'{held_bytes[k], k == held - 1, cause});
		end
		held = '0;
	endtask

	task automatic log_fault(input bit orphan, input frame_beat_t want, input frame_beat_t seen);
		fails++;
		if (fails <= 10) begin
			if (orphan)
				$display("unexpected frame byte: got byte %02h last %0b cause %0d",
					seen.data, seen.last, seen.cause);
			else
				$display({"frame byte mismatch: expected byte %02h last %0b cause %0d,",
					" got byte %02h last %0b cause %0d"},
					want.data, want.last, want.cause, seen.data, seen.last, seen.cause);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		frame_beat_t seen;
		frame_beat_t want;
		if (!arst_n) begin
			frame_due.delete();
			held = '0;
			quiet = '0;
			cfg = cfg_t'{1'b0, GAP_RESET};
			fails = 0;
			pending = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				if (paddr[PADDR_W-1:2] == REG_ASCII)
					cfg.ascii_mode = pwdata[0];
				else if (paddr[PADDR_W-1:2] == REG_GAP)
					cfg.gap_ticks = pwdata[15:0];
			end
			if (frame.valid && frame.ready) begin
				seen = frame_beat_t'{frame.frame_byte, frame.frame_last, frame.end_cause};
				if (frame_due.size() == 0) begin
					log_fault(1'b1, seen, seen);
				end else begin
					want = frame_due.pop_front();
					if (seen.data !== want.data || seen.last !== want.last ||
						seen.cause !== want.cause)
						log_fault(1'b0, want, seen);
				end
			end
			if (rx.valid && rx.ready) begin
				if (rx.action == ACT_TICK) begin
					if (quiet != SIL_MAX)
						quiet = quiet + 1'b1;
					if (quiet > cfg.gap_ticks && held != 0)
						queue_frame(CAUSE_GAP);
				end else begin
					quiet = '0;
					if (cfg.ascii_mode && rx.rx_byte == COLON_BYTE) begin
						if (held != 0)
							queue_frame(CAUSE_START);
						held_bytes[0] = rx.rx_byte;
						held = CNT_W'(1);
					end else if (held < MAX_FRAME) begin
						held_bytes[held] = rx.rx_byte;
						held = held + 1'b1;
					end
					if (held >= MAX_FRAME)
						queue_frame(CAUSE_FULL);
				end
			end
			pending = frame_due.size();
		end
	end

endmodule

// ----- bench/tb_serial_idle_gap_framer.sv -----
`timescale 1ns / 100ps
// Top of the serial idle gap framer bench: clock, reset, register writes, bus events
// and frame channel back-pressure; the checker beside the block gives the fail count.
// Depends on sigf_pkg, the sigf interfaces, serial_idle_gap_framer and sigf_frame_checker.
module tb_serial_idle_gap_framer;
	import sigf_pkg::*;

	localparam logic [PADDR_W-1:0] ADDR_ASCII = PADDR_W'(REG_ASCII) << 2;
	localparam logic [PADDR_W-1:0] ADDR_GAP   = PADDR_W'(REG_GAP) << 2;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [31:0]        pwdata;
	logic [31:0]        prdata;
	logic               pready;
	int                 fails;
	int                 pending;
	int                 rx_calm;
	cfg_t               plan [8];

	sigf_rx_if    rx_ch();
	sigf_frame_if frame_ch();

	serial_idle_gap_framer dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.rx      (rx_ch),
		.frame   (frame_ch)
	);

	sigf_frame_checker chk (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.pready  (pready),
		.rx      (rx_ch),
		.frame   (frame_ch),
		.fails   (fails),
		.pending (pending)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	initial begin
		#50_000_000;
		$display("status: fail");
		$finish;
	end

	function automatic int rx_idle();
		int r;
		if (rx_calm > 0) begin
			rx_calm--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 3) begin
			rx_calm = $urandom_range(20, 120);
			return 0;
		end
		if (r < 60)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	task automatic push_event(input logic act, input byte_t b);
		int idle;
		idle = rx_idle();
		repeat (idle) begin
			@(negedge clk);
			rx_ch.valid = 1'b0;
		end
		@(negedge clk);
		rx_ch.valid = 1'b1;
		rx_ch.action = act;
		rx_ch.rx_byte = b;
		do @(posedge clk); while (!rx_ch.ready);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		rx_ch.valid = 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [31:0] data);
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = addr;
		pwdata = data;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	task automatic set_config(input cfg_t c);
		logic [31:0] junk;
		junk = $urandom();
		apb_write(ADDR_ASCII, {junk[31:1], c.ascii_mode});
		apb_write(ADDR_GAP, {junk[31:16], c.gap_ticks});
	endtask

	// back-pressure on the frame channel: calm stretches, short and long stalls
	initial begin
		int stall;
		int calm;
		int r;
		stall = 0;
		calm = 0;
		frame_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (calm > 0) begin
				frame_ch.ready = 1'b1;
				calm--;
			end else if (stall > 0) begin
				frame_ch.ready = 1'b0;
				stall--;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 3) begin
					calm = $urandom_range(50, 300);
					frame_ch.ready = 1'b1;
				end else if (r < 70) begin
					frame_ch.ready = 1'b1;
				end else if (r < 95) begin
					frame_ch.ready = 1'b0;
					stall = $urandom_range(0, 3);
				end else begin
					frame_ch.ready = 1'b0;
					stall = $urandom_range(10, 60);
				end
			end
		end
	end

	initial begin
		int n;
		int total;
		int len;
		int ticks;
		int pick;
		byte_t b;
		cfg_t c;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		rx_ch.valid = 1'b0;
		rx_ch.action = ACT_BYTE;
		rx_ch.rx_byte = '0;
		rx_calm = 0;
		total = 0;
		plan[0] = cfg_t'{1'b0, 16'd100};
		plan[1] = cfg_t'{1'b1, 16'd0};
		plan[2] = cfg_t'{1'b1, 16'd3};
		plan[3] = cfg_t'{1'b0, 16'hFFFF};
		plan[4] = cfg_t'{1'b1, 16'hFFFF};
		plan[5] = cfg_t'{1'b0, 16'd1};
		plan[6] = cfg_t'{1'b1, 16'd7};
		plan[7] = cfg_t'{1'b0, 16'd0};
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset settings: colon is plain data, frame ends after 101 quiet ticks
		push_event(ACT_BYTE, 8'h00);
		push_event(ACT_BYTE, 8'hFF);
		push_event(ACT_BYTE, COLON_BYTE);
		push_event(ACT_BYTE, 8'h01);
		repeat (GAP_RESET + 1) push_event(ACT_TICK, 8'hA5);
		wait_drained();

		// zero gap: first tick after a byte ends the frame, idle tick with empty store
		set_config(cfg_t'{1'b0, 16'd0});
		push_event(ACT_BYTE, 8'h5A);
		push_event(ACT_TICK, 8'h00);
		push_event(ACT_TICK, 8'hFF);
		wait_drained();

		// colon framing: colon into empty store, colon closing a frame, lone colon
		set_config(cfg_t'{1'b1, 16'd0});
		push_event(ACT_BYTE, COLON_BYTE);
		push_event(ACT_BYTE, 8'h80);
		push_event(ACT_BYTE, 8'h7F);
		push_event(ACT_BYTE, COLON_BYTE);
		push_event(ACT_TICK, COLON_BYTE);
		wait_drained();

		// a byte in the middle of the silence restarts the count
		set_config(cfg_t'{1'b0, 16'd2});
		push_event(ACT_BYTE, 8'h11);
		push_event(ACT_TICK, 8'h00);
		push_event(ACT_TICK, 8'h00);
		push_event(ACT_BYTE, 8'h22);
		repeat (3) push_event(ACT_TICK, 8'h00);
		wait_drained();

		for (int p = 0; total < 140 || p < 8; p++) begin
			if (p < 8)
				c = plan[p];
			else
				c = cfg_t'{1'($urandom_range(0, 1)), 16'($urandom_range(0, 9))};
			set_config(c);
			n = 0;
			while (n < 16) begin
				pick = $urandom_range(0, 99);
				if (pick < 65) begin
					if ($urandom_range(0, 9) == 0)
						len = $urandom_range(40, 70);
					else
						len = $urandom_range(1, 10);
					for (int k = 0; k < len; k++) begin
						if ($urandom_range(0, 11) == 0)
							b = COLON_BYTE;
						else
							b = byte_t'($urandom());
						push_event(ACT_BYTE, b);
					end
					if (c.gap_ticks < 120)
						ticks = c.gap_ticks + $urandom_range(0, 3);
					else
						ticks = $urandom_range(0, 4);
					repeat (ticks) push_event(ACT_TICK, byte_t'($urandom()));
					n += len + ticks;
				end else begin
					push_event(pick < 85 ? ACT_TICK : ACT_BYTE, byte_t'($urandom()));
					n++;
				end
			end
			total += n;
			wait_drained();
		end

		repeat (140) @(negedge clk);
		if (fails == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
